// ===== rtl/core/mclb_pkg.sv =====
// Shared types and codes for the multi-channel LED blinker.
package mclb_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_START    = 2'd1;
    localparam logic [1:0] MODE_STOP     = 2'd2;
    localparam logic [1:0] MODE_STOP_ALL = 2'd3;

    // Fixed field widths of the stream items
    localparam int COUNT_W  = 16;
    localparam int IN_TIME_W = 16;
    localparam int MASK_W   = 8;

    // One result item
    typedef struct packed {
        logic              start_taken;
        logic [MASK_W-1:0] busy_mask;
        logic [MASK_W-1:0] lit_mask;
    } result_t;

    // Status of one channel after a tick step
    typedef struct packed {
        logic keep_active;
        logic lit;
    } tick_stat_t;

endpackage

// ===== rtl/core/mclb_state_mem.sv =====
// Per-channel timing memory: one write port, one registered read port.
module mclb_state_mem #(
    parameter int WIDTH = 82,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mclb_tick_unit.sv =====
// One channel's tick step: phase and period counters, lit and done decision.
module mclb_tick_unit #(
    parameter int TIME_BITS = 16
) (
    input  logic [mclb_pkg::COUNT_W-1:0] repeats_set,
    input  logic [TIME_BITS-1:0]         on_ticks,
    input  logic [TIME_BITS-1:0]         off_ticks,
    input  logic [TIME_BITS:0]           phase,
    input  logic [mclb_pkg::COUNT_W-1:0] periods_done,
    output logic [TIME_BITS:0]           phase_next,
    output logic [mclb_pkg::COUNT_W-1:0] periods_done_next,
    output mclb_pkg::tick_stat_t         stat
);

    logic [TIME_BITS:0]           period;
    logic [TIME_BITS:0]           phase_inc;
    logic                         wrap;
    logic [mclb_pkg::COUNT_W:0]   done_inc;

    // Advance phase, wrap at the end of a period
    always_comb begin
        period    = {1'b0, on_ticks} + {1'b0, off_ticks};
        phase_inc = phase + {{TIME_BITS{1'b0}}, 1'b1};
        wrap      = (phase_inc >= period);
        phase_next = wrap ? '0 : phase_inc;
        done_inc  = {1'b0, periods_done} + {{mclb_pkg::COUNT_W{1'b0}}, wrap};
        periods_done_next = done_inc[mclb_pkg::COUNT_W-1:0];
        stat.keep_active  = (done_inc < {1'b0, repeats_set});
        stat.lit          = stat.keep_active && (phase_next < {1'b0, on_ticks});
    end

endmodule

// ===== rtl/core/mclb_out_buf.sv =====
// Result output register with one spare slot so the core can finish while stalled.
module mclb_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  mclb_pkg::result_t res,
    output logic              pend_valid,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata    // [7:0] lit_mask, [15:8] busy_mask, [16] start_taken
);

    mclb_pkg::result_t out_reg;
    mclb_pkg::result_t pend_reg;
    logic              out_valid_reg;
    logic              pend_valid_reg;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Control: spare slot drains first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= pend_valid_reg || res_valid;
            pend_valid_reg <= pend_valid_reg && res_valid;
        end else if (res_valid) begin
            pend_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (pend_valid_reg) begin
                out_reg  <= pend_reg;
                pend_reg <= res;
            end else if (res_valid) begin
                out_reg <= res;
            end
        end else if (res_valid) begin
            pend_reg <= res;
        end
    end

    assign pend_valid = pend_valid_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, out_reg};

endmodule

// ===== rtl/core/multi_channel_led_blinker.sv =====
// Top level of the multi-channel LED blinker.
//
// Input items arrive on s_tvalid/s_tready; s_tuser carries the kind
// (tick, start, stop, stop all) and s_tdata the channel and the timing.
// Every accepted item gives exactly one result item on m_tvalid/m_tready
// with the lit and busy masks after that item and a start-taken flag.
//
// Start, stop and stop-all items are decided in the cycle of acceptance and
// their result is registered; input stays open unless the spare slot is full.
// A tick item sweeps the channel timing memory one channel per cycle
// (read, update, write back); the memory's single read port sets this pace.
//
// After reset all channels are idle and dark. Channel timing entries need
// no clearing: an entry's data is only used while its channel is active, and a
// start writes the whole entry. There is no clearing pass.
//
// If the receiver stalls, one result waits on the output and one more can
// be held in a spare slot; input is then refused until the slot drains.
module multi_channel_led_blinker #(
    parameter int CHANNELS  = 8,
    parameter int TIME_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [2:0] channel, [18:3] repeat_count, [34:19] on_time,
                                   // [50:35] off_time
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] lit_mask, [15:8] busy_mask, [16] start_taken
);

    localparam int CW      = mclb_pkg::COUNT_W;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W   = CW + TIME_BITS + TIME_BITS + (TIME_BITS + 1) + CW;
    localparam int ON_LO   = CW;
    localparam int OFF_LO  = CW + TIME_BITS;
    localparam int PH_LO   = CW + 2 * TIME_BITS;
    localparam int PD_LO   = CW + 3 * TIME_BITS + 1;
    localparam int PAD_W   = (CHANNELS > mclb_pkg::MASK_W) ? CHANNELS : mclb_pkg::MASK_W;
    localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;

    typedef enum logic {ST_IDLE, ST_SWEEP} state_t;

    state_t              state_reg, state_next;
    logic [CH_W-1:0]     cnt_reg, cnt_next;
    logic [CHANNELS-1:0] active_reg, active_next;
    logic [CHANNELS-1:0] lit_reg, lit_next;

    // Input fields
    logic [1:0]              mode;
    logic [2:0]              channel;
    logic [CW-1:0]           repeat_count;
    logic [mclb_pkg::IN_TIME_W-1:0] on_time, off_time;
    logic [TIME_BITS-1:0]    on_sat, off_sat;
    logic [CH_W-1:0]         ch_idx;
    logic                    ch_ok;
    logic                    s_accept;

    // Memory ports
    logic                wr_en;
    logic [CH_W-1:0]     wr_addr;
    logic [ENT_W-1:0]    wr_data;
    logic [CH_W-1:0]     rd_addr;
    logic [ENT_W-1:0]    rd_data;

    // Tick unit
    logic [TIME_BITS:0]   ph_next;
    logic [CW-1:0]        pd_next;
    mclb_pkg::tick_stat_t stat;

    // Result path
    logic              res_valid;
    mclb_pkg::result_t res;
    logic              start_ok;
    logic              pend_valid;
    logic [PAD_W-1:0]  lit_pad, busy_pad;

    assign mode         = s_tuser;
    assign channel      = s_tdata[2:0];
    assign repeat_count = s_tdata[18:3];
    assign on_time      = s_tdata[34:19];
    assign off_time     = s_tdata[50:35];

    // Times saturate to the configured width
    assign on_sat  = (64'(on_time) > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                                : TIME_BITS'(on_time);
    assign off_sat = (64'(off_time) > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                                 : TIME_BITS'(off_time);
    assign ch_idx  = CH_W'(channel);
    assign ch_ok   = (32'(channel) < CHANNELS);

    assign s_tready = (state_reg == ST_IDLE) && !pend_valid;
    assign s_accept = s_tvalid && s_tready;

    mclb_state_mem #(
        .WIDTH (ENT_W),
        .DEPTH (CHANNELS),
        .AW    (CH_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mclb_tick_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_tick (
        .repeats_set       (rd_data[CW-1:0]),
        .on_ticks          (rd_data[ON_LO +: TIME_BITS]),
        .off_ticks         (rd_data[OFF_LO +: TIME_BITS]),
        .phase             (rd_data[PH_LO +: TIME_BITS + 1]),
        .periods_done      (rd_data[PD_LO +: CW]),
        .phase_next        (ph_next),
        .periods_done_next (pd_next),
        .stat              (stat)
    );

    // Sequencer: item decode, channel sweep, memory write-back
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        lit_next    = lit_reg;
        wr_en       = 1'b0;
        wr_addr     = ch_idx;
        wr_data     = {{CW{1'b0}}, {(TIME_BITS + 1){1'b0}}, off_sat, on_sat, repeat_count};
        rd_addr     = '0;
        res_valid   = 1'b0;
        start_ok    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (mode)
                        mclb_pkg::MODE_TICK: begin
                            state_next = ST_SWEEP;
                            cnt_next   = '0;
                        end
                        mclb_pkg::MODE_START: begin
                            res_valid = 1'b1;
                            if (ch_ok && !active_reg[ch_idx] && repeat_count != '0
                                && on_sat != '0) begin
                                start_ok             = 1'b1;
                                wr_en                = 1'b1;
                                active_next[ch_idx]  = 1'b1;
                                lit_next[ch_idx]     = 1'b1;
                            end
                        end
                        mclb_pkg::MODE_STOP: begin
                            res_valid = 1'b1;
                            if (ch_ok) begin
                                active_next[ch_idx] = 1'b0;
                                lit_next[ch_idx]    = 1'b0;
                            end
                        end
                        default: begin
                            res_valid   = 1'b1;
                            active_next = '0;
                            lit_next    = '0;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // Entry cnt_reg is on the read port; next entry is requested now
                rd_addr = cnt_reg + CH_W'(1);
                wr_addr = cnt_reg;
                wr_data = {pd_next, ph_next, rd_data[OFF_LO +: TIME_BITS],
                           rd_data[ON_LO +: TIME_BITS], rd_data[CW-1:0]};
                if (active_reg[cnt_reg]) begin
                    wr_en                 = 1'b1;
                    active_next[cnt_reg]  = stat.keep_active;
                    lit_next[cnt_reg]     = stat.lit;
                end
                cnt_next = cnt_reg + CH_W'(1);
                if (cnt_reg == CH_W'(CHANNELS - 1)) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and channel flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            active_reg <= '0;
            lit_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            lit_reg    <= lit_next;
        end
    end

    // Result item from the state after this item
    assign lit_pad  = PAD_W'(lit_next);
    assign busy_pad = PAD_W'(active_next);
    assign res.lit_mask    = lit_pad[mclb_pkg::MASK_W-1:0];
    assign res.busy_mask   = busy_pad[mclb_pkg::MASK_W-1:0];
    assign res.start_taken = start_ok;

    mclb_out_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res_valid  (res_valid),
        .res        (res),
        .pend_valid (pend_valid),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // A lit channel is always an active one
    a_lit_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (lit_reg & ~active_reg) == '0)
        else $error("lit channel not active");

    // A held spare result implies a waiting output
    a_pend_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid |-> m_tvalid)
        else $error("spare slot full with output empty");

    // A tick starts a sweep
    a_tick_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && mode == mclb_pkg::MODE_TICK) |=> (state_reg == ST_SWEEP))
        else $error("tick did not start sweep");

    // No input is taken during a sweep
    a_sweep_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> !s_tready)
        else $error("input ready during sweep");

endmodule

// ===== bench/blink_mask_checker.sv =====
// Result checker for the LED blinker: predicts the masks of every item and compares.
module blink_mask_checker #(
    parameter int CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // [2:0] channel, [18:3] repeat_count, [34:19] on_time,
                                   // [50:35] off_time
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] lit_mask, [15:8] busy_mask, [16] start_taken
    output int          mismatches,
    output int          pending
);

    // Per-channel blink state, kept apart from the block
    logic        ch_active  [CHANNELS];
    logic        ch_lit     [CHANNELS];
    logic [15:0] ch_repeats [CHANNELS];
    logic [15:0] ch_on      [CHANNELS];
    logic [15:0] ch_off     [CHANNELS];
    logic [16:0] ch_phase   [CHANNELS];
    logic [15:0] ch_done    [CHANNELS];

    // Masks still owed by the block, oldest first
    mclb_pkg::result_t owed_masks [$];
    mclb_pkg::result_t got_masks;
    mclb_pkg::result_t want_masks;
    int                err_count = 0;
    int                owed_count = 0;

    assign mismatches = err_count;
    assign pending    = owed_count;

    function automatic void clear_channel(int c);
        ch_active[c]  = 1'b0;
        ch_lit[c]     = 1'b0;
        ch_repeats[c] = '0;
        ch_on[c]      = '0;
        ch_off[c]     = '0;
        ch_phase[c]   = '0;
        ch_done[c]    = '0;
    endfunction

    // One tick: advance phase, wrap into the next period, retire finished channels
    function automatic void tick_channel(int c);
        logic [16:0] period;
        if (ch_active[c]) begin
            period      = {1'b0, ch_on[c]} + {1'b0, ch_off[c]};
            ch_phase[c] = ch_phase[c] + 17'd1;
            if (ch_phase[c] >= period) begin
                ch_phase[c] = '0;
                ch_done[c]  = ch_done[c] + 16'd1;
            end
            ch_lit[c] = (ch_phase[c] < {1'b0, ch_on[c]});
            if (ch_done[c] >= ch_repeats[c])
                clear_channel(c);
        end
    endfunction

    // Apply one input item to the channel state and return the masks it yields
    function automatic mclb_pkg::result_t next_masks(logic [1:0] mode, logic [2:0] chan,
                                                     logic [15:0] cnt, logic [15:0] on_t,
                                                     logic [15:0] off_t);
        mclb_pkg::result_t r;
        int                c;
        r = '0;
        case (mode)
            mclb_pkg::MODE_TICK: begin
                for (c = 0; c < CHANNELS; c++)
                    tick_channel(c);
            end
            mclb_pkg::MODE_START: begin
                if (int'(chan) < CHANNELS && !ch_active[chan] && cnt != 0 && on_t != 0) begin
                    ch_repeats[chan] = cnt;
                    ch_on[chan]      = on_t;
                    ch_off[chan]     = off_t;
                    ch_phase[chan]   = '0;
                    ch_done[chan]    = '0;
                    ch_active[chan]  = 1'b1;
                    ch_lit[chan]     = 1'b1;
                    r.start_taken    = 1'b1;
                end
            end
            mclb_pkg::MODE_STOP: begin
                if (int'(chan) < CHANNELS)
                    clear_channel(int'(chan));
            end
            mclb_pkg::MODE_STOP_ALL: begin
                for (c = 0; c < CHANNELS; c++)
                    clear_channel(c);
            end
            default: ;
        endcase
        for (c = 0; c < CHANNELS && c < mclb_pkg::MASK_W; c++) begin
            r.lit_mask[c]  = ch_lit[c];
            r.busy_mask[c] = ch_active[c];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int want_v, int got_v);
        $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want_v, got_v, $time);
        err_count++;
    endtask

    // Results are retired before new items are queued, so a same-edge pair never collides
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++)
                clear_channel(c);
            owed_masks.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_masks = m_tdata[16:0];
                if (owed_masks.size() == 0) begin
                    report_mismatch("unexpected result item", 0, int'(got_masks));
                end else begin
                    want_masks = owed_masks.pop_front();
                    if (got_masks.lit_mask != want_masks.lit_mask)
                        report_mismatch("lit_mask", want_masks.lit_mask, got_masks.lit_mask);
                    if (got_masks.busy_mask != want_masks.busy_mask)
                        report_mismatch("busy_mask", want_masks.busy_mask, got_masks.busy_mask);
                    if (got_masks.start_taken != want_masks.start_taken)
                        report_mismatch("start_taken", want_masks.start_taken,
                                        got_masks.start_taken);
                end
            end
            if (s_tvalid && s_tready)
                owed_masks.push_back(next_masks(s_tuser, s_tdata[2:0], s_tdata[18:3],
                                                s_tdata[34:19], s_tdata[50:35]));
        end
        owed_count <= owed_masks.size();
    end

endmodule

// ===== bench/multi_channel_led_blinker_tb.sv =====
// Testbench top for the LED blinker: clock, reset, stimulus, flow control and verdict.
module multi_channel_led_blinker_tb;

    localparam int CHANNELS     = 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = CHANNELS + 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 425;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = mclb_pkg::MODE_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int mismatches;
    int pending;

    // Pacing knobs, percent per cycle
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off requests, served by the receiver process
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    multi_channel_led_blinker #(
        .CHANNELS (CHANNELS),
        .TIME_BITS(16)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    blink_mask_checker #(
        .CHANNELS(CHANNELS)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles without any accepted item on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, with random idle cycles ahead of it, and wait until it is taken
    task automatic send_item(logic [1:0] mode, logic [2:0] chan, logic [15:0] cnt,
                             logic [15:0] on_t, logic [15:0] off_t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, off_t, on_t, cnt, chan};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly ticks and short well-formed blink runs, with some rejects and full-range values
    task automatic send_random_item();
        int          pick;
        int          shape;
        logic [2:0]  chan;
        logic [15:0] cnt;
        logic [15:0] on_t;
        logic [15:0] off_t;
        pick  = $urandom_range(99);
        shape = $urandom_range(99);
        chan  = 3'($urandom_range(7));
        cnt   = 16'($urandom_range(65535));
        on_t  = 16'($urandom_range(65535));
        off_t = 16'($urandom_range(65535));
        if (pick < 50) begin
            send_item(mclb_pkg::MODE_TICK, chan, cnt, on_t, off_t);
        end else if (pick < 82) begin
            if (shape < 80) begin
                cnt   = 16'($urandom_range(4, 1));
                on_t  = 16'($urandom_range(4, 1));
                off_t = 16'($urandom_range(4));
            end else if (shape < 88) begin
                if ($urandom_range(1))
                    cnt = '0;
                else
                    on_t = '0;
            end
            send_item(mclb_pkg::MODE_START, chan, cnt, on_t, off_t);
        end else if (pick < 96) begin
            send_item(mclb_pkg::MODE_STOP, chan, cnt, on_t, off_t);
        end else begin
            send_item(mclb_pkg::MODE_STOP_ALL, chan, cnt, on_t, off_t);
        end
    endtask

    initial begin
        int run_phase;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: rejects, busy start, steady on, extreme fields, stops
        send_item(mclb_pkg::MODE_TICK,     3'd0, 16'd0,     16'd0,     16'd0);
        send_item(mclb_pkg::MODE_START,    3'd0, 16'd0,     16'd5,     16'd5);
        send_item(mclb_pkg::MODE_START,    3'd1, 16'd3,     16'd0,     16'd2);
        send_item(mclb_pkg::MODE_START,    3'd2, 16'd2,     16'd1,     16'd1);
        send_item(mclb_pkg::MODE_START,    3'd2, 16'd9,     16'd9,     16'd9);
        send_item(mclb_pkg::MODE_START,    3'd3, 16'd1,     16'd2,     16'd0);
        send_item(mclb_pkg::MODE_START,    3'd7, 16'hFFFF,  16'hFFFF,  16'hFFFF);
        send_item(mclb_pkg::MODE_START,    3'd5, 16'd1,     16'd1,     16'hFFFF);
        repeat (5)
            send_item(mclb_pkg::MODE_TICK, 3'd7, 16'hFFFF,  16'hFFFF,  16'hFFFF);
        send_item(mclb_pkg::MODE_STOP,     3'd7, 16'd0,     16'd0,     16'd0);
        send_item(mclb_pkg::MODE_STOP,     3'd0, 16'd0,     16'd0,     16'd0);
        send_item(mclb_pkg::MODE_START,    3'd6, 16'hFFFF,  16'hFFFF,  16'd0);
        send_item(mclb_pkg::MODE_START,    3'd4, 16'd1,     16'd1,     16'd0);
        send_item(mclb_pkg::MODE_TICK,     3'd0, 16'd0,     16'd0,     16'd0);
        send_item(mclb_pkg::MODE_STOP_ALL, 3'd0, 16'd0,     16'd0,     16'd0);
        send_item(mclb_pkg::MODE_TICK,     3'd0, 16'd0,     16'd0,     16'd0);

        // Random phases with different pacing
        for (run_phase = 0; run_phase < 4; run_phase++) begin
            case (run_phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            // Back-pressure: receiver holds off while the sender keeps offering
            if (run_phase == 0)
                hold_requests++;
            repeat (PHASE_ITEMS)
                send_random_item();
        end

        // Drain
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mclb_pkg.sv
rtl/core/mclb_state_mem.sv
rtl/core/mclb_tick_unit.sv
rtl/core/mclb_out_buf.sv
rtl/core/multi_channel_led_blinker.sv
bench/blink_mask_checker.sv
bench/multi_channel_led_blinker_tb.sv
